// ===== design/pcv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcv_pkg
// Shared types and constants of the packet checksum verifier: packet byte
// positions, the input item and the result item.
// ----------------------------------------------------------------------------
package pcv_pkg;

    // width of the in-packet byte counter (header plus up to 255 payload bytes)
    localparam int unsigned POS_W = 9;

    // byte positions inside a packet
    localparam logic [POS_W-1:0] POS_ID       = 9'd0;
    localparam logic [POS_W-1:0] POS_LENGTH   = 9'd1;
    localparam logic [POS_W-1:0] POS_STAMP_B0 = 9'd2;
    localparam logic [POS_W-1:0] POS_STAMP_B1 = 9'd3;
    localparam logic [POS_W-1:0] POS_STAMP_B2 = 9'd4;
    localparam logic [POS_W-1:0] POS_STAMP_B3 = 9'd5;
    localparam logic [POS_W-1:0] POS_SUM_LO   = 9'd6;
    localparam logic [POS_W-1:0] POS_SUM_HI   = 9'd7;

    // one received byte with its framing flag
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       start_of_packet;
    } pcv_in_t;

    // one completed packet report
    typedef struct packed {
        logic [7:0]  packet_id;
        logic [7:0]  payload_length;
        logic [31:0] time_stamp;
        logic [15:0] computed_sum;
        logic        sum_ok;
    } pcv_res_t;

endpackage

// ===== design/pcv_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcv_rx_if
// Byte stream channel into the verifier: valid/ready with one packet byte
// and its start flag.
// ----------------------------------------------------------------------------
interface pcv_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       start_of_packet;

    modport source (output valid, output rx_byte, output start_of_packet, input ready);
    modport sink   (input valid, input rx_byte, input start_of_packet, output ready);
endinterface

// ===== design/pcv_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcv_res_if
// Result channel of the verifier: valid/ready with one packet report.
// ----------------------------------------------------------------------------
interface pcv_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packet_id;
    logic [7:0]  payload_length;
    logic [31:0] time_stamp;
    logic [15:0] computed_sum;
    logic        sum_ok;

    modport source (
        output valid, output packet_id, output payload_length, output time_stamp,
        output computed_sum, output sum_ok, input ready
    );
    modport sink (
        input valid, input packet_id, input payload_length, input time_stamp,
        input computed_sum, input sum_ok, output ready
    );
endinterface

// ===== design/pcv_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcv_in_stage
// Input register: holds one byte item until the framing core consumes it,
// and refills in the same cycle so bytes can stream back to back.
// ----------------------------------------------------------------------------
module pcv_in_stage
    import pcv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    pcv_rx_if.sink   rx,
    input  logic     take,
    output logic     item_valid,
    output pcv_in_t  item
);

    logic    valid_reg;
    logic    valid_next;
    pcv_in_t data_reg;
    logic    load;

    // accept when empty or when the held item leaves this cycle
    assign rx.ready = !valid_reg || take;
    assign load     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.rx_byte         <= rx.rx_byte;
            data_reg.start_of_packet <= rx.start_of_packet;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// ===== design/pcv_frame_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcv_frame_core
// Packet framing and running sums: takes one byte item per cycle while
// the result register is free, captures header fields, updates the two
// wrapping 8-bit sums and raises a report on the last byte of a packet.
// ----------------------------------------------------------------------------
module pcv_frame_core
    import pcv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  pcv_in_t   item,
    input  logic      out_free,
    output logic      take,
    output logic      res_valid,
    output pcv_res_t  res
);

    logic             in_frame_reg,  in_frame_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [7:0]       sum1_reg,      sum1_next;
    logic [7:0]       sum2_reg,      sum2_next;
    logic [7:0]       id_reg,        id_next;
    logic [7:0]       length_reg,    length_next;
    logic [31:0]      stamp_reg,     stamp_next;
    logic [15:0]      rx_sum_reg,    rx_sum_next;

    logic             frame_eff;
    logic [POS_W-1:0] pos_eff;
    logic [7:0]       sum1_eff;
    logic [7:0]       sum2_eff;
    logic [7:0]       sum1_add;
    logic [7:0]       sum2_add;
    logic             covered;
    logic             done;
    logic [7:0]       b;

    // an item moves on whenever the result register can take a report
    assign take = item_valid && out_free;
    assign b    = item.rx_byte;

    // a start flag restarts framing and clears the sums
    assign frame_eff = item.start_of_packet || in_frame_reg;
    assign pos_eff   = item.start_of_packet ? POS_ID : pos_reg;
    assign sum1_eff  = item.start_of_packet ? 8'd0 : sum1_reg;
    assign sum2_eff  = item.start_of_packet ? 8'd0 : sum2_reg;

    // fletcher style sums, wrapping modulo 256
    assign covered  = (pos_eff != POS_SUM_LO) && (pos_eff != POS_SUM_HI);
    assign sum1_add = sum1_eff + b;
    assign sum2_add = sum2_eff + sum1_add;

    // last byte: checksum high byte plus length payload bytes
    assign done = (pos_eff >= POS_SUM_HI)
               && (pos_eff == (POS_SUM_HI + {1'b0, length_reg}));

    // field capture and next state
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        sum1_next     = sum1_reg;
        sum2_next     = sum2_reg;
        id_next       = id_reg;
        length_next   = length_reg;
        stamp_next    = stamp_reg;
        rx_sum_next   = rx_sum_reg;
        res_valid     = 1'b0;

        if (take && frame_eff)
        begin
            sum1_next = covered ? sum1_add : sum1_eff;
            sum2_next = covered ? sum2_add : sum2_eff;

            unique case (pos_eff)
                POS_ID:       id_next           = b;
                POS_LENGTH:   length_next       = b;
                POS_STAMP_B0: stamp_next        = {24'd0, b};
                POS_STAMP_B1: stamp_next[15:8]  = b;
                POS_STAMP_B2: stamp_next[23:16] = b;
                POS_STAMP_B3: stamp_next[31:24] = b;
                POS_SUM_LO:   rx_sum_next[7:0]  = b;
                POS_SUM_HI:   rx_sum_next[15:8] = b;
                default:      ;
            endcase

            if (done)
            begin
                in_frame_next = 1'b0;
                pos_next      = POS_ID;
                res_valid     = 1'b1;
            end
            else
            begin
                in_frame_next = 1'b1;
                pos_next      = pos_eff + 1'b1;
            end
        end
    end

    // report fields built from the updated state
    always_comb
    begin
        res.packet_id      = id_next;
        res.payload_length = length_next;
        res.time_stamp     = stamp_next;
        res.computed_sum   = {sum2_next, sum1_next};
        res.sum_ok         = ({sum2_next, sum1_next} == rx_sum_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= POS_ID;
            sum1_reg     <= 8'd0;
            sum2_reg     <= 8'd0;
            id_reg       <= 8'd0;
            length_reg   <= 8'd0;
            stamp_reg    <= 32'd0;
            rx_sum_reg   <= 16'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            sum1_reg     <= sum1_next;
            sum2_reg     <= sum2_next;
            id_reg       <= id_next;
            length_reg   <= length_next;
            stamp_reg    <= stamp_next;
            rx_sum_reg   <= rx_sum_next;
        end
    end

endmodule

// ===== design/pcv_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcv_out_stage
// Result register: holds one packet report until the sink takes it, and
// reloads in the same cycle the previous report leaves.
// ----------------------------------------------------------------------------
module pcv_out_stage
    import pcv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  pcv_res_t  res,
    output logic      out_free,
    pcv_res_if.source result
);

    logic     valid_reg;
    logic     valid_next;
    pcv_res_t data_reg;

    // free when empty or draining this cycle
    assign out_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // report capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.packet_id      = data_reg.packet_id;
    assign result.payload_length = data_reg.payload_length;
    assign result.time_stamp     = data_reg.time_stamp;
    assign result.computed_sum   = data_reg.computed_sum;
    assign result.sum_ok         = data_reg.sum_ok;

endmodule

// ===== design/packet_checksum_verifier_unit.sv =====
`timescale 1ns / 1ps
// Packet checksum verifier. Bytes of a received packet enter on rx in wire
// order (id, length, four timestamp bytes least significant first, checksum
// low then high, then length payload bytes); start_of_packet on a byte makes
// it the id of a new packet and drops any partial one. Bytes outside a packet
// are dropped. Two 8-bit sums wrap modulo 256 over every byte but the two
// checksum bytes, and on the last byte one report leaves on result with the
// header fields, the computed checksum (second sum high, first sum low) and
// sum_ok. One byte is taken every clock cycle; a byte passes the input
// register and the framing logic, and its report is loaded into the result
// register as the byte leaves the input register and is offered from there.
// Input stalls only while the result register holds a report the sink has
// not taken.
// ----------------------------------------------------------------------------
// packet_checksum_verifier_unit
// Top level: input register, framing and sum core, result register.
// ----------------------------------------------------------------------------
module packet_checksum_verifier_unit
    import pcv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pcv_rx_if.sink    rx,
    pcv_res_if.source result
);

    logic     take;
    logic     item_valid;
    pcv_in_t  item;
    logic     out_free;
    logic     res_valid;
    pcv_res_t res;

    // byte input register
    pcv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // framing and running sums
    pcv_frame_core u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // report register
    pcv_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .out_free (out_free),
        .result   (result)
    );

endmodule

// ===== tb/sv/pcv_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcv_report_checker
// Watches the byte and report channels of the packet checksum verifier. It
// frames the accepted bytes on its own and keeps the packet reports they must
// produce. Each accepted report is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module pcv_report_checker
    import pcv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pcv_rx_if    rx,
    pcv_res_if   result,
    output int   fail_count,
    output int   outstanding,
    output int   reports_checked
);

    // reports due from bytes already accepted, oldest first
    pcv_res_t pending_reports[$];

    // framing state of the byte stream
    logic [POS_W-1:0] next_pos;
    logic             framing;
    logic [7:0]       sum_lo;
    logic [7:0]       sum_hi;
    logic [7:0]       id_q;
    logic [7:0]       len_q;
    logic [31:0]      stamp_q;
    logic [15:0]      wire_sum_q;

    pcv_res_t got;
    pcv_res_t want;

    // advance the framing by one accepted byte, queue a report on the last one
    task automatic frame_byte(input pcv_in_t item);
        pcv_res_t         rep;
        logic [POS_W-1:0] p;
        logic [7:0]       b;
        b = item.rx_byte;
        if (item.start_of_packet)
        begin
            framing  = 1'b1;
            next_pos = POS_ID;
            sum_lo   = 8'd0;
            sum_hi   = 8'd0;
        end
        // bytes outside a packet are dropped
        if (!framing)
            return;
        p = next_pos;
        if (p == POS_SUM_LO)
            wire_sum_q[7:0] = b;
        else if (p == POS_SUM_HI)
            wire_sum_q[15:8] = b;
        else
        begin
            if (p == POS_ID)
                id_q = b;
            else if (p == POS_LENGTH)
                len_q = b;
            else if (p <= POS_STAMP_B3)
            begin
                if (p == POS_STAMP_B0)
                    stamp_q = 32'd0;
                stamp_q[(p - POS_STAMP_B0) * 8 +: 8] = b;
            end
            // sums wrap at 8 bits, no mod-255 fold
            sum_lo = sum_lo + b;
            sum_hi = sum_hi + sum_lo;
        end
        if (p >= POS_SUM_HI && p == POS_SUM_HI + len_q)
        begin
            rep.packet_id      = id_q;
            rep.payload_length = len_q;
            rep.time_stamp     = stamp_q;
            rep.computed_sum   = {sum_hi, sum_lo};
            rep.sum_ok         = ({sum_hi, sum_lo} == wire_sum_q);
            pending_reports = {pending_reports, rep};
            framing  = 1'b0;
            next_pos = POS_ID;
        end
        else
            next_pos = p + 1'b1;
    endtask

    // compare accepted reports first, then frame the accepted byte
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            next_pos   = POS_ID;
            framing    = 1'b0;
            sum_lo     = 8'd0;
            sum_hi     = 8'd0;
            id_q       = 8'd0;
            len_q      = 8'd0;
            stamp_q    = 32'd0;
            wire_sum_q = 16'd0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = {result.packet_id, result.payload_length, result.time_stamp,
                       result.computed_sum, result.sum_ok};
                if (pending_reports.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected report id=%02h len=%0d stamp=%08h %s",
                                 $realtime, got.packet_id, got.payload_length,
                                 got.time_stamp,
                                 $sformatf("sum=%04h ok=%0b", got.computed_sum,
                                           got.sum_ok));
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    reports_checked++;
                    if (got.packet_id !== want.packet_id ||
                        got.payload_length !== want.payload_length ||
                        got.time_stamp !== want.time_stamp ||
                        got.computed_sum !== want.computed_sum ||
                        got.sum_ok !== want.sum_ok)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: report mismatch", $realtime);
                            $display("  expected id=%02h len=%0d stamp=%08h sum=%04h ok=%0b",
                                     want.packet_id, want.payload_length, want.time_stamp,
                                     want.computed_sum, want.sum_ok);
                            $display("  actual   id=%02h len=%0d stamp=%08h sum=%04h ok=%0b",
                                     got.packet_id, got.payload_length, got.time_stamp,
                                     got.computed_sum, got.sum_ok);
                        end
                        fail_count++;
                    end
                end
            end
            if (rx.valid && rx.ready)
                frame_byte({rx.rx_byte, rx.start_of_packet});
        end
        outstanding = pending_reports.size();
    end

endmodule

// ===== tb/sv/tb_packet_checksum_verifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_checksum_verifier_unit
// Drives packet byte streams into the checksum verifier: a few directed
// packets for the framing corners, then random packets with good and corrupted
// checksums, truncated packets and stray bytes, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_packet_checksum_verifier_unit;
    import pcv_pkg::*;

    localparam int PACKET_BYTES = 1100;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 3000;

    logic clk = 1'b0;
    logic rst_n;

    pcv_rx_if  rx_ch ();
    pcv_res_if res_ch ();

    int  fail_count;
    int  outstanding;
    int  reports_checked;
    int  quiet_cycles;
    int  bytes_sent;
    int  noise_bytes;
    int  packets_sent;
    int  long_holds;
    bit  calm;
    bit  hold_long;

    packet_checksum_verifier_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    pcv_report_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx              (rx_ch),
        .result          (res_ch),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .reports_checked (reports_checked)
    );

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // offer one byte after an optional gap and wait until it is taken
    task automatic put_byte(input logic [7:0] b, input logic sop);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            rx_ch.valid           <= 1'b0;
            rx_ch.rx_byte         <= 8'($urandom_range(0, 255));
            rx_ch.start_of_packet <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_ch.valid           <= 1'b1;
        rx_ch.rx_byte         <= b;
        rx_ch.start_of_packet <= sop;
        do
            @(posedge clk);
        while (!rx_ch.ready);
    endtask

    // build a packet with its checksum, optionally corrupt it or cut it short
    task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                               input logic [31:0] stamp, input bit bad_sum,
                               input int cut);
        logic [7:0] pkt[$];
        logic [7:0] s1;
        logic [7:0] s2;
        int         r;
        int         n;
        s1 = 8'd0;
        s2 = 8'd0;
        pkt = {pkt, id};
        pkt = {pkt, len};
        for (int i = 0; i < 4; i++)
            pkt = {pkt, stamp[8 * i +: 8]};
        pkt = {pkt, 8'd0};
        pkt = {pkt, 8'd0};
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                pkt = {pkt, 8'h00};
            else if (r == 1)
                pkt = {pkt, 8'hFF};
            else
                pkt = {pkt, 8'($urandom_range(0, 255))};
        end
        foreach (pkt[i])
        begin
            if (i != POS_SUM_LO && i != POS_SUM_HI)
            begin
                s1 = s1 + pkt[i];
                s2 = s2 + s1;
            end
        end
        pkt[POS_SUM_LO] = s1;
        pkt[POS_SUM_HI] = s2;
        if (bad_sum)
        begin
            if ($urandom_range(0, 1))
                pkt[POS_SUM_HI] = pkt[POS_SUM_HI] ^ 8'($urandom_range(1, 255));
            else
                pkt[POS_SUM_LO] = pkt[POS_SUM_LO] ^ 8'($urandom_range(1, 255));
        end
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int i = 0; i < n; i++)
            put_byte(pkt[i], i == 0);
        bytes_sent += n;
        packets_sent++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
                long_holds++;
            end
            else
            begin
                n = calm ? 0 : pick_gap();
                if (n == 0)
                    res_ch.ready <= 1'b1;
                else
                begin
                    res_ch.ready <= 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    // no handshake on either side for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("[packet_checksum_verifier_unit] ERROR");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        int         kind;
        logic [7:0] len;
        bit         did_big;
        bit         did_drain;
        bit         did_hold;
        did_big   = 1'b0;
        did_drain = 1'b0;
        did_hold  = 1'b0;
        rst_n                 = 1'b0;
        rx_ch.valid           = 1'b0;
        rx_ch.rx_byte         = 8'd0;
        rx_ch.start_of_packet = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // byte while waiting for a start is dropped
        put_byte(8'hFF, 1'b0);
        // zero length packet with all-ones header, good checksum
        send_packet(8'hFF, 8'd0, 32'hFFFF_FFFF, 1'b0, 0);
        // byte after a completed packet is dropped
        put_byte(8'h00, 1'b0);
        // all-zero header, cut before its last byte: the next start takes over
        send_packet(8'h00, 8'd1, 32'h0000_0000, 1'b0, 8);
        // zero length packet with a wrong checksum
        send_packet(8'hA5, 8'd0, 32'h0123_4567, 1'b1, 0);

        // random packets, mostly well formed
        while (bytes_sent < PACKET_BYTES)
        begin
            calm = (bytes_sent >= 200 && bytes_sent < 350);
            if (!did_hold && bytes_sent >= 500)
            begin
                did_hold  = 1'b1;
                hold_long = 1'b1;
            end
            if (!did_drain && bytes_sent >= 800)
            begin
                // stop offering until every report has come out
                did_drain = 1'b1;
                @(negedge clk);
                rx_ch.valid <= 1'b0;
                wait (outstanding == 0);
                repeat (5) @(negedge clk);
            end
            if ($urandom_range(0, 99) < 85)
                len = 8'($urandom_range(0, 12));
            else
                len = 8'($urandom_range(13, 40));
            kind = $urandom_range(0, 99);
            if (!did_big && bytes_sent >= 400)
            begin
                did_big = 1'b1;
                send_packet(8'($urandom_range(0, 255)), 8'd255, $urandom, 1'b0, 0);
            end
            else if (kind < 70)
                send_packet(8'($urandom_range(0, 255)), len, $urandom, 1'b0, 0);
            else if (kind < 85)
                send_packet(8'($urandom_range(0, 255)), len, $urandom, 1'b1, 0);
            else if (kind < 95)
                send_packet(8'($urandom_range(0, 255)), len, $urandom,
                            1'($urandom_range(0, 1)), $urandom_range(1, len + 7));
            else
            begin
                // stray bytes, now and then with a start flag
                repeat ($urandom_range(1, 4))
                begin
                    put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                    noise_bytes++;
                end
            end
        end
        calm = 1'b0;

        // drain
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(negedge clk);

        $display("covered %0d packet bytes in %0d packets plus %0d stray bytes, %0d reports checked",
                 bytes_sent, packets_sent, noise_bytes, reports_checked);
        $display("lengths up to 255, %0d long result hold-off, one full drain pause, %0d failures",
                 long_holds, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("[packet_checksum_verifier_unit] OK");
        else
            $display("[packet_checksum_verifier_unit] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pcv_pkg.sv
design/pcv_rx_if.sv
design/pcv_res_if.sv
design/pcv_in_stage.sv
design/pcv_frame_core.sv
design/pcv_out_stage.sv
design/packet_checksum_verifier_unit.sv
tb/sv/pcv_report_checker.sv
tb/sv/tb_packet_checksum_verifier_unit.sv
